### src/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the pattern chain sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Fixed field widths of the command word and result word
  localparam int CMD_W   = 2;
  localparam int BEAT_W  = 16;
  localparam int REQ_W   = 8;
  localparam int SLOT_W  = 6;
  localparam int IN_ID_W = 16;
  localparam int BARS_W  = 8;
  localparam int OUT_W   = 6;

  // Configuration registers
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH  = 1'b1;

  // A bar is 16 beats
  localparam int BAR_LOG2 = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEAT       = 2'd0,
    CMD_REQUEST    = 2'd1,
    CMD_PATTERN_ID = 2'd2,
    CMD_CHAIN_ENTRY = 2'd3
  } pcs_cmd_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic hit;
  } pcs_tok_t;

endpackage

### src/pcs_cell.sv
// ----------------------------------------------------------------------------
// pcs_cell
// One pattern table slot: holds a pattern ID and checks the passing token.
// ----------------------------------------------------------------------------
module pcs_cell #(
  parameter int ID_BITS  = 16,
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcs_pkg::pcs_tok_t      tok_in,
  input  logic [IDX_W-1:0]       idx_in,
  input  logic [ID_BITS-1:0]     key,
  input  logic [pcs_pkg::CNT_W-1:0] npat,
  input  logic                   wr_en,
  input  logic [pcs_pkg::SLOT_W-1:0] wr_slot,
  input  logic [ID_BITS-1:0]     wr_id,
  output pcs_pkg::pcs_tok_t      tok_out,
  output logic [IDX_W-1:0]       idx_out
);
  import pcs_pkg::*;

  logic [ID_BITS-1:0] id_r;
  pcs_tok_t           tok_r;
  pcs_tok_t           tok_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   idx_nxt;
  logic               live;
  logic               match;

  // slot is live only while it lies below the loaded pattern count
  assign live  = (CELL_IDX < int'(npat));
  assign match = tok_in.valid && !tok_in.hit && live && (id_r == key);

  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.hit   = tok_in.hit || match;
    idx_nxt       = match ? IDX_W'(CELL_IDX) : idx_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (wr_en && (int'(wr_slot) == CELL_IDX)) begin
      id_r <= wr_id;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

### src/pcs_search_row.sv
// ----------------------------------------------------------------------------
// pcs_search_row
// Row of pattern cells; a search token walks one cell per cycle.
// ----------------------------------------------------------------------------
module pcs_search_row #(
  parameter int MAX_PATTERNS = 64,
  parameter int ID_BITS      = 16,
  parameter int IDX_W        = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   launch,
  input  logic [ID_BITS-1:0]     key,
  input  logic [pcs_pkg::CNT_W-1:0] npat,
  input  logic                   wr_en,
  input  logic [pcs_pkg::SLOT_W-1:0] wr_slot,
  input  logic [ID_BITS-1:0]     wr_id,
  output pcs_pkg::pcs_tok_t      res_tok,
  output logic [IDX_W-1:0]       res_idx
);
  import pcs_pkg::*;

  pcs_tok_t         tok [0:MAX_PATTERNS];
  logic [IDX_W-1:0] idx [0:MAX_PATTERNS];

  assign tok[0].valid = launch;
  assign tok[0].hit   = 1'b0;
  assign idx[0]       = '0;

  for (genvar g = 0; g < MAX_PATTERNS; g++) begin : g_cell
    pcs_cell #(
      .ID_BITS  (ID_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[g]),
      .idx_in  (idx[g]),
      .key     (key),
      .npat    (npat),
      .wr_en   (wr_en),
      .wr_slot (wr_slot),
      .wr_id   (wr_id),
      .tok_out (tok[g+1]),
      .idx_out (idx[g+1])
    );
  end

  assign res_tok = tok[MAX_PATTERNS];
  assign res_idx = idx[MAX_PATTERNS];

endmodule

### src/pattern_chain_sequencer_core.sv
// ----------------------------------------------------------------------------
// pattern_chain_sequencer_core
// Picks the drum pattern for each audio block from manual requests and a
// pattern chain; pattern IDs are looked up in a row of search cells.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | words
//  ----------+-------------------------+-----------------------------------
//  command   | start / busy            | in_cmd, in_beat_*, in_block_end,
//            |                         | in_request_index, in_table_slot,
//            |                         | in_entry_id, in_entry_bars
//  result    | out_valid (1-cycle)     | out_playing_pattern, out_chain_step
//  config    | cfg_we                  | cfg_index, cfg_wdata
//
//  - Beat, request and table words are taken without raising busy.
//  - A block end answers on the next cycle, except when the chain steps:
//    then busy holds while the chain position wraps, the chain memory is
//    read and the token crosses the search row, and the result shows on
//    the cycle busy drops.
//  - Synchronous active-low reset clears control state; table contents are
//    undefined until written.
//  - Results are a one-cycle strobe; the receiver cannot stall them.
//
module pattern_chain_sequencer_core #(
  parameter int MAX_PATTERNS = 64,
  parameter int MAX_CHAIN    = 64,
  parameter int ID_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [pcs_pkg::CMD_W-1:0]        in_cmd,
  input  logic                             in_beat_valid,
  input  logic [pcs_pkg::BEAT_W-1:0]       in_beat_index,
  input  logic                             in_block_end,
  input  logic [pcs_pkg::REQ_W-1:0]        in_request_index,
  input  logic [pcs_pkg::SLOT_W-1:0]       in_table_slot,
  input  logic [pcs_pkg::IN_ID_W-1:0]      in_entry_id,
  input  logic [pcs_pkg::BARS_W-1:0]       in_entry_bars,
  // result channel
  output logic                             out_valid,
  output logic [pcs_pkg::OUT_W-1:0]        out_playing_pattern,
  output logic [pcs_pkg::OUT_W-1:0]        out_chain_step,
  // config port
  input  logic                             cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcs_pkg::CNT_W-1:0]        cfg_wdata
);
  import pcs_pkg::*;

  // Largest usable pattern count is capped by the 7-bit register
  localparam int NpMax  = (MAX_PATTERNS < 127) ? MAX_PATTERNS : 127;
  localparam int PIdxW  = (NpMax > 1) ? $clog2(NpMax) : 1;
  localparam int ChainW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int ModSteps = CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_LAUNCH,
    ST_SEARCH
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CNT_W-1:0]  pat_count_r, pat_count_nxt;
  logic [CNT_W-1:0]  chain_len_r, chain_len_nxt;

  // sequencer state
  logic [PIdxW-1:0]  play_index_r, play_index_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [REQ_W-1:0]  pend_index_r, pend_index_nxt;
  logic [OUT_W-1:0]  chain_pos_r, chain_pos_nxt;
  logic [BARS_W-1:0] bars_left_r, bars_left_nxt;
  logic              bound_seen_r, bound_seen_nxt;

  // chain step working registers
  logic [PIdxW-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [2:0]        step_cnt_r, step_cnt_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_pat_r, out_pat_nxt;
  logic [OUT_W-1:0]  out_step_r, out_step_nxt;

  // chain table memory
  logic [ID_BITS-1:0] chain_id_mem   [0:MAX_CHAIN-1];
  logic [BARS_W-1:0]  chain_bars_mem [0:MAX_CHAIN-1];
  logic [ID_BITS-1:0] rd_id_r;
  logic [BARS_W-1:0]  rd_bars_r;
  logic [ChainW-1:0]  rd_addr;

  // misc
  logic               accept;
  logic               beat_bound;
  logic [CNT_W-1:0]   npat;
  logic [CNT_W-1:0]   nchain;
  logic [PIdxW-1:0]   cur_clamp;
  logic [PIdxW-1:0]   pend_clamp;
  logic [ID_BITS-1:0] wr_id;
  logic               pat_wr;
  logic               chain_wr;
  logic [CNT_W:0]     mod_trial;
  logic [CNT_W:0]     mod_diff;
  pcs_tok_t           res_tok;
  logic [PIdxW-1:0]   res_idx;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign beat_bound = in_beat_valid && (in_beat_index[BAR_LOG2-1:0] == '0);
  assign wr_id      = ID_BITS'(in_entry_id);
  assign pat_wr     = accept && (in_cmd == CMD_PATTERN_ID);
  assign chain_wr   = accept && (in_cmd == CMD_CHAIN_ENTRY)
                      && (int'(in_table_slot) < MAX_CHAIN);

  // oversized register values saturate at the table depth
  assign npat   = (int'(pat_count_r) > MAX_PATTERNS) ? CNT_W'(MAX_PATTERNS) : pat_count_r;
  assign nchain = (int'(chain_len_r) > MAX_CHAIN) ? CNT_W'(MAX_CHAIN) : chain_len_r;

  // stale play index and the request are both clamped to the last pattern
  assign cur_clamp  = (CNT_W'(play_index_r) >= npat) ? PIdxW'(npat - 1'b1) : play_index_r;
  assign pend_clamp = (pend_index_r >= REQ_W'(npat)) ? PIdxW'(npat - 1'b1)
                                                     : PIdxW'(pend_index_r);

  // one restoring-division step of (chain_pos + 1) mod nchain per cycle
  assign mod_trial = {rem_r, dvd_r[CNT_W-1]};
  assign mod_diff  = mod_trial - {1'b0, nchain};

  assign rd_addr = ChainW'(rem_r);

  pcs_search_row #(
    .MAX_PATTERNS (MAX_PATTERNS),
    .ID_BITS      (ID_BITS),
    .IDX_W        (PIdxW)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .launch  (state_r == ST_LAUNCH),
    .key     (rd_id_r),
    .npat    (npat),
    .wr_en   (pat_wr),
    .wr_slot (in_table_slot),
    .wr_id   (wr_id),
    .res_tok (res_tok),
    .res_idx (res_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    pat_count_nxt  = pat_count_r;
    chain_len_nxt  = chain_len_r;
    play_index_nxt = play_index_r;
    pend_valid_nxt = pend_valid_r;
    pend_index_nxt = pend_index_r;
    chain_pos_nxt  = chain_pos_r;
    bars_left_nxt  = bars_left_r;
    bound_seen_nxt = bound_seen_r;
    cur_nxt        = cur_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    step_cnt_nxt   = step_cnt_r;
    out_valid_nxt  = 1'b0;
    out_pat_nxt    = out_pat_r;
    out_step_nxt   = out_step_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_COUNT: pat_count_nxt = cfg_wdata;
        REG_CHAIN_LENGTH:  chain_len_nxt = cfg_wdata;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            CMD_BEAT: begin
              if (!in_block_end) begin
                bound_seen_nxt = bound_seen_r || beat_bound;
              end else begin
                bound_seen_nxt = 1'b0;
                out_step_nxt   = chain_pos_r;
                priority if (npat == '0) begin
                  // nothing loaded: answer pattern 0, keep all state but bound_seen
                  out_valid_nxt = 1'b1;
                  out_pat_nxt   = '0;
                end else if ((bound_seen_r || beat_bound) && pend_valid_r) begin
                  play_index_nxt = pend_clamp;
                  pend_valid_nxt = 1'b0;
                  chain_pos_nxt  = '0;
                  bars_left_nxt  = BARS_W'(1);
                  out_valid_nxt  = 1'b1;
                  out_pat_nxt    = OUT_W'(pend_clamp);
                  out_step_nxt   = '0;
                end else if ((bound_seen_r || beat_bound) && (nchain != '0)
                             && (bars_left_r <= BARS_W'(1))) begin
                  // chain steps: wrap position, then look up the entry ID
                  cur_nxt      = cur_clamp;
                  dvd_nxt      = CNT_W'(chain_pos_r) + 1'b1;
                  rem_nxt      = '0;
                  step_cnt_nxt = '0;
                  state_nxt    = ST_MOD;
                end else if ((bound_seen_r || beat_bound) && (nchain != '0)) begin
                  bars_left_nxt = bars_left_r - 1'b1;
                  out_valid_nxt = 1'b1;
                  out_pat_nxt   = OUT_W'(cur_clamp);
                end else begin
                  out_valid_nxt = 1'b1;
                  out_pat_nxt   = OUT_W'(cur_clamp);
                end
              end
            end
            CMD_REQUEST: begin
              pend_valid_nxt = 1'b1;
              pend_index_nxt = in_request_index;
            end
            CMD_PATTERN_ID: begin
              // stored in the search row
            end
            CMD_CHAIN_ENTRY: begin
              // stored in the chain memory
            end
          endcase
        end
      end
      ST_MOD: begin
        rem_nxt      = (mod_trial >= {1'b0, nchain}) ? mod_diff[CNT_W-1:0]
                                                      : mod_trial[CNT_W-1:0];
        dvd_nxt      = dvd_r << 1;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (step_cnt_r == 3'(ModSteps - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (res_tok.valid) begin
          play_index_nxt = res_tok.hit ? res_idx : cur_r;
          chain_pos_nxt  = OUT_W'(rem_r);
          bars_left_nxt  = (rd_bars_r == '0) ? BARS_W'(1) : rd_bars_r;
          out_valid_nxt  = 1'b1;
          out_pat_nxt    = OUT_W'(res_tok.hit ? res_idx : cur_r);
          out_step_nxt   = OUT_W'(rem_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pat_count_r  <= '0;
      chain_len_r  <= '0;
      play_index_r <= '0;
      pend_valid_r <= 1'b0;
      pend_index_r <= '0;
      chain_pos_r  <= '0;
      bars_left_r  <= '0;
      bound_seen_r <= 1'b0;
      step_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pat_count_r  <= pat_count_nxt;
      chain_len_r  <= chain_len_nxt;
      play_index_r <= play_index_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_index_r <= pend_index_nxt;
      chain_pos_r  <= chain_pos_nxt;
      bars_left_r  <= bars_left_nxt;
      bound_seen_r <= bound_seen_nxt;
      step_cnt_r   <= step_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    out_pat_r  <= out_pat_nxt;
    out_step_r <= out_step_nxt;
  end

  // chain table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (chain_wr) begin
      chain_id_mem[ChainW'(in_table_slot)]   <= wr_id;
      chain_bars_mem[ChainW'(in_table_slot)] <= in_entry_bars;
    end
    rd_id_r   <= chain_id_mem[rd_addr];
    rd_bars_r <= chain_bars_mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_playing_pattern = out_pat_r;
  assign out_chain_step      = out_step_r;

  // results only leave once the sequencer is back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // the search token may only emerge while waiting for it
  a_token_search: assert property (@(posedge clk) disable iff (!rst_n)
    res_tok.valid |-> (state_r == ST_SEARCH))
    else $error("search token outside search phase");

  // every accepted block end either answers next cycle or starts a chain step
  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_BEAT) && in_block_end) |=>
      (out_valid_r || (state_r == ST_MOD)))
    else $error("block end dropped");

endmodule
